[design/bcl_pkg.sv]
package bcl_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;

    localparam int CLICK_TIMEOUT_W = 8;
    localparam int LONG_PRESS_W    = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [CLICK_TIMEOUT_W-1:0] CLICK_TIMEOUT_RST = 8'd30;
    localparam logic [LONG_PRESS_W-1:0]    LONG_PRESS_RST    = 16'd200;

    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_TIMEOUT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 1'b1;

    localparam logic [1:0] CLICK_NONE   = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;

    typedef struct packed {
        logic       press_latch;
        logic       edge_lock;
        logic [1:0] press_tally;
        logic       long_fired;
    } bcl_flags_t;

endpackage

[design/bcl_step.sv]
module bcl_step
    import bcl_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                       key,
    input  logic [CLICK_TIMEOUT_W-1:0] click_timeout,
    input  logic [LONG_PRESS_W-1:0]    long_press_ticks,
    input  bcl_flags_t                 flags,
    input  logic [COUNTER_WIDTH-1:0]   wait_count,
    input  logic [COUNTER_WIDTH-1:0]   hold_count,
    input  logic [COUNTER_WIDTH-1:0]   long_count,
    output bcl_flags_t                 flags_next,
    output logic [COUNTER_WIDTH-1:0]   wait_next,
    output logic [COUNTER_WIDTH-1:0]   hold_next,
    output logic [COUNTER_WIDTH-1:0]   long_next,
    output logic [1:0]                 click,
    output logic                       long_press
);

    localparam int CMP_W = (COUNTER_WIDTH > LONG_PRESS_W) ? COUNTER_WIDTH : LONG_PRESS_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    logic [COUNTER_WIDTH-1:0] wait_inc;
    logic [COUNTER_WIDTH-1:0] hold_inc;
    logic [COUNTER_WIDTH-1:0] long_inc;
    logic [COUNTER_WIDTH-1:0] ct_ext;

    assign wait_inc = (wait_count == CNT_MAX) ? wait_count : wait_count + 1'b1;
    assign hold_inc = (hold_count == CNT_MAX) ? hold_count : hold_count + 1'b1;
    assign long_inc = (long_count == CNT_MAX) ? long_count : long_count + 1'b1;
    assign ct_ext   = COUNTER_WIDTH'(click_timeout);

    always_comb
    begin
        flags_next = flags;
        wait_next  = wait_count;
        click      = CLICK_NONE;
        hold_next  = key ? hold_inc : '0;

        if (key)
        begin
            flags_next.press_latch = 1'b1;
        end

        if (!flags.edge_lock)
        begin
            if (flags_next.press_latch)
            begin
                if (flags.press_tally != 2'd3)
                begin
                    flags_next.press_tally = flags.press_tally + 2'd1;
                end
                flags_next.edge_lock = 1'b1;
            end
            if (flags_next.press_tally == 2'd2)
            begin
                flags_next.press_tally = 2'd0;
                wait_next              = '0;
                click                  = CLICK_DOUBLE;
            end
        end

        if (click != CLICK_DOUBLE)
        begin
            if (!key)
            begin
                flags_next.press_latch = 1'b0;
                flags_next.edge_lock   = 1'b0;
            end
            if (flags_next.press_tally == 2'd1)
            begin
                wait_next = wait_inc;
                if (wait_inc > ct_ext && hold_next < ct_ext)
                begin
                    flags_next.press_tally = 2'd0;
                    wait_next              = '0;
                    click                  = CLICK_SINGLE;
                end
            end
        end

        long_next  = long_count;
        long_press = 1'b0;
        if (key)
        begin
            if (!flags.long_fired)
            begin
                long_next = long_inc;
            end
        end
        else
        begin
            long_next             = '0;
            flags_next.long_fired = 1'b0;
        end
        if (CMP_W'(long_next) > CMP_W'(long_press_ticks))
        begin
            flags_next.long_fired = 1'b1;
            long_next             = '0;
            long_press            = 1'b1;
        end
    end

endmodule

[design/button_click_long_press_detector.sv]
// Button click and long-press detector.
// The input channel (in_valid, in_ready, key_pressed) carries one sampled
// button level per item, one item per tick of the debounce clock.
// Each accepted item yields exactly one result item on the output channel
// (out_valid, out_ready, click_event, long_press_event): click_event is 0 for
// none, 1 for a single click and 2 for a double click, and long_press_event
// pulses on the item where the hold first exceeds long_press_ticks.
// out_valid is registered and rises in the cycle after acceptance.
// Throughput is one item per cycle: the classifier state and the result
// register both update in the accepting cycle, so in_ready stays high while
// out_ready is high. When the receiver stalls, the result holds in the
// output register and in_ready drops until it is taken.
// Reset clears all counters and flags, empties the output register and
// loads click_timeout = 30 and long_press_ticks = 200. The configuration
// port (cfg_wr_en, cfg_index, cfg_wdata) writes register 0 (click_timeout,
// low 8 bits) or register 1 (long_press_ticks) and should only be used
// while no item is in flight.
module button_click_long_press_detector
    import bcl_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   key_pressed,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             click_event,
    output logic                   long_press_event,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [CLICK_TIMEOUT_W-1:0] click_timeout_reg;
    logic [LONG_PRESS_W-1:0]    long_press_ticks_reg;
    bcl_flags_t                 flags_reg;
    bcl_flags_t                 flags_next;
    logic [COUNTER_WIDTH-1:0]   wait_reg;
    logic [COUNTER_WIDTH-1:0]   wait_next;
    logic [COUNTER_WIDTH-1:0]   hold_reg;
    logic [COUNTER_WIDTH-1:0]   hold_next;
    logic [COUNTER_WIDTH-1:0]   long_reg;
    logic [COUNTER_WIDTH-1:0]   long_next;
    logic [1:0]                 click_next;
    logic                       long_press_next;
    logic                       out_valid_reg;
    logic [1:0]                 click_reg;
    logic                       long_press_reg;
    logic                       accept;

    assign in_ready         = !out_valid_reg || out_ready;
    assign accept           = in_valid && in_ready;
    assign out_valid        = out_valid_reg;
    assign click_event      = click_reg;
    assign long_press_event = long_press_reg;

    bcl_step #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_step (
        .key              (key_pressed),
        .click_timeout    (click_timeout_reg),
        .long_press_ticks (long_press_ticks_reg),
        .flags            (flags_reg),
        .wait_count       (wait_reg),
        .hold_count       (hold_reg),
        .long_count       (long_reg),
        .flags_next       (flags_next),
        .wait_next        (wait_next),
        .hold_next        (hold_next),
        .long_next        (long_next),
        .click            (click_next),
        .long_press       (long_press_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_timeout_reg    <= CLICK_TIMEOUT_RST;
            long_press_ticks_reg <= LONG_PRESS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CLICK_TIMEOUT: click_timeout_reg    <= cfg_wdata[CLICK_TIMEOUT_W-1:0];
                REG_LONG_PRESS:    long_press_ticks_reg <= cfg_wdata[LONG_PRESS_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg     <= '0;
            wait_reg      <= '0;
            hold_reg      <= '0;
            long_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                flags_reg <= flags_next;
                wait_reg  <= wait_next;
                hold_reg  <= hold_next;
                long_reg  <= long_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            click_reg      <= click_next;
            long_press_reg <= long_press_next;
        end
    end

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && click_next == CLICK_DOUBLE) |=>
            (flags_reg.press_tally == 2'd0 && wait_reg == '0))
        else $error("double click did not clear the press tally");

    a_release_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !key_pressed) |=>
            (!flags_reg.long_fired && hold_reg == '0 && !flags_reg.edge_lock))
        else $error("release did not re-arm the detector");

    a_long_press_once: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && long_press_next) |=> (flags_reg.long_fired && long_reg == '0))
        else $error("long press did not latch its fired flag");

endmodule
